// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera pan target tracker package
// Field widths, register indexes, reset values, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // Word field widths
    localparam int PX_W       = 16;
    localparam int TGT_W      = 18;
    localparam int SPD_W      = 21;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register widths
    localparam int MARGIN_W   = 14;
    localparam int RATIO_W    = 9;
    localparam int LIMIT_W    = 20;
    localparam int RATE_W     = 8;
    localparam int WIN_CFG_W  = 7;

    // Register reset values
    localparam int COURT_WIDTH_PX = 1920;
    localparam int LEFT_RESET     = 0;
    localparam int MARGIN_RESET   = 0;
    localparam int RATIO_RESET    = 128;
    localparam int LIMIT_RESET    = 16000;
    localparam int RATE_RESET     = 30;
    localparam int WIN_RESET      = 30;

    // Q1.8 blend
    localparam int RATIO_ONE   = 256;
    localparam int RATIO_SHIFT = 8;
    localparam int ROUND_HALF  = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_BOUND    = 3'd0,
        REG_RIGHT_BOUND   = 3'd1,
        REG_EDGE_MARGIN   = 3'd2,
        REG_MERGE_RATIO   = 3'd3,
        REG_SPEED_LIMIT   = 3'd4,
        REG_FRAME_RATE    = 3'd5,
        REG_WINDOW_LENGTH = 3'd6
    } cpt_reg_t;

    typedef enum logic [4:0] {
        ST_ACCUM = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } cpt_state_t;

    typedef struct packed {
        logic accum;
        logic div_load;
        logic div_step;
        logic commit;
        logic load_out;
    } cpt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } cpt_status_t;

endpackage

// ===== hw/rtl/cpt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write when enabled, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences accumulation, mean division, products and result hand-off.
// ----------------------------------------------------------------------------
module cpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 frame_end,
    output logic                 in_ready,
    output cpt_pkg::cpt_cmd_t    cmd,
    input  cpt_pkg::cpt_status_t status
);
    import cpt_pkg::*;

    cpt_state_t state_reg;
    cpt_state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready  = 1'b1;
                cmd.accum = in_valid;
                if (in_valid && frame_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cpt_datapath.sv =====
// ----------------------------------------------------------------------------
// Tracker datapath
// Configuration registers, frame accumulators, shift-subtract divider,
// mean history memory, blend and speed products, clamps and result register.
// ----------------------------------------------------------------------------
module cpt_datapath #(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_PLAYERS   = 32,
    parameter int POS_FRAC_BITS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [cpt_pkg::PX_W-1:0]         player_x,
    input  logic                             has_player,
    input  logic [cpt_pkg::PX_W-1:0]         ball_x,
    input  logic                             has_ball,
    input  logic                             out_ready,
    input  cpt_pkg::cpt_cmd_t                cmd,
    output cpt_pkg::cpt_status_t             status,
    output logic                             out_valid,
    output logic signed [cpt_pkg::TGT_W-1:0] pan_target,
    output logic [cpt_pkg::PX_W-1:0]         mean_x,
    output logic signed [cpt_pkg::SPD_W-1:0] pan_speed
);
    import cpt_pkg::*;

    localparam int CNT_W       = $clog2(MAX_PLAYERS + 1);
    localparam int SUM_W       = PX_W + CNT_W;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int AW          = $clog2(HISTORY_DEPTH);
    localparam int HC_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int WIN_W       = (WIN_CFG_W > HC_W) ? WIN_CFG_W : HC_W;
    localparam int PROD_W      = RATIO_W + PX_W;
    localparam int BLEND_W     = PROD_W + 1;
    localparam int SPROD_W     = PX_W + 1 + RATE_W;
    localparam int RIGHT_RAW   = COURT_WIDTH_PX << POS_FRAC_BITS;
    localparam int RIGHT_RESET = (RIGHT_RAW > 65535) ? 65535 : RIGHT_RAW;

    // Configuration registers
    logic [PX_W-1:0]      left_bound_reg;
    logic [PX_W-1:0]      right_bound_reg;
    logic [MARGIN_W-1:0]  edge_margin_reg;
    logic [RATIO_W-1:0]   merge_ratio_reg;
    logic [LIMIT_W-1:0]   speed_limit_reg;
    logic [RATE_W-1:0]    frame_rate_reg;
    logic [WIN_CFG_W-1:0] window_length_reg;

    // Frame accumulators
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PX_W-1:0]      first_reg;
    logic [PX_W-1:0]      ball_reg;
    logic                 ball_valid_reg;

    // Divider
    logic [SUM_W-1:0]     quot_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_diff;
    logic                 trial_fits;

    // History
    logic [AW-1:0]        ptr_reg;
    logic [HC_W-1:0]      hcount_reg;
    logic                 primed_reg;
    logic [PX_W-1:0]      fill_reg;
    logic [PX_W-1:0]      prev_mean_reg;
    logic [HC_W-1:0]      win_len;
    logic [WIN_W-1:0]     win_ext;
    logic [HC_W-1:0]      ptr_ext;
    logic [HC_W-1:0]      rd_sum;
    logic [AW-1:0]        rd_addr;
    logic [PX_W-1:0]      ram_q;

    // Commit values
    logic [RATIO_W-1:0]   ratio_c;
    logic [RATIO_W-1:0]   ratio_inv;
    logic [PX_W-1:0]      mean_c;
    logic [PX_W-1:0]      ball_c;
    logic [PX_W-1:0]      fill_c;
    logic [PX_W-1:0]      old_c;
    logic signed [PX_W:0] diff_c;
    logic [PROD_W-1:0]    prod_mean_c;
    logic [PROD_W-1:0]    prod_ball_c;
    logic signed [SPROD_W-1:0] speed_prod_c;

    // Product registers
    logic [PROD_W-1:0]         prod_mean_reg;
    logic [PROD_W-1:0]         prod_ball_reg;
    logic signed [SPROD_W-1:0] speed_prod_reg;
    logic [PX_W-1:0]           mean_reg;

    // Clamp stage
    logic [BLEND_W-1:0]        blend_c;
    logic signed [TGT_W-1:0]   tgt_raw;
    logic signed [TGT_W-1:0]   lo_c;
    logic signed [TGT_W-1:0]   hi_c;
    logic signed [TGT_W-1:0]   tgt_c;
    logic signed [SPROD_W-1:0] lim_c;
    logic signed [SPROD_W-1:0] spd_c;

    // Result register
    logic                      out_valid_reg;
    logic signed [TGT_W-1:0]   target_reg;
    logic [PX_W-1:0]           mean_out_reg;
    logic signed [SPD_W-1:0]   speed_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_bound_reg    <= PX_W'(LEFT_RESET);
            right_bound_reg   <= PX_W'(RIGHT_RESET);
            edge_margin_reg   <= MARGIN_W'(MARGIN_RESET);
            merge_ratio_reg   <= RATIO_W'(RATIO_RESET);
            speed_limit_reg   <= LIMIT_W'(LIMIT_RESET);
            frame_rate_reg    <= RATE_W'(RATE_RESET);
            window_length_reg <= WIN_CFG_W'(WIN_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cpt_reg_t'(cfg_index))
                REG_LEFT_BOUND:    left_bound_reg    <= cfg_data[PX_W-1:0];
                REG_RIGHT_BOUND:   right_bound_reg   <= cfg_data[PX_W-1:0];
                REG_EDGE_MARGIN:   edge_margin_reg   <= cfg_data[MARGIN_W-1:0];
                REG_MERGE_RATIO:   merge_ratio_reg   <= cfg_data[RATIO_W-1:0];
                REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_FRAME_RATE:    frame_rate_reg    <= cfg_data[RATE_W-1:0];
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WIN_CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Accumulate players and latch the first ball; clear on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            first_reg      <= '0;
            ball_reg       <= '0;
            ball_valid_reg <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (has_player && (count_reg < CNT_W'(MAX_PLAYERS)))
            begin
                if (count_reg == '0)
                begin
                    first_reg <= player_x;
                end
                sum_reg   <= sum_reg + SUM_W'(player_x);
                count_reg <= count_reg + 1'b1;
            end
            if (has_ball && !ball_valid_reg)
            begin
                ball_reg       <= ball_x;
                ball_valid_reg <= 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            first_reg      <= '0;
            ball_reg       <= '0;
            ball_valid_reg <= 1'b0;
        end
    end

    // Restoring division, one quotient bit a cycle
    assign trial      = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_fits = (trial >= {1'b0, count_reg});
    assign trial_diff = trial - {1'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quot_reg <= sum_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[SUM_W-2:0], trial_fits};
        end
    end

    // Clamp window and form the history read address
    always_comb
    begin
        win_ext = WIN_W'(window_length_reg);
        if (win_ext == '0)
        begin
            win_len = HC_W'(1);
        end
        else if (win_ext > WIN_W'(HISTORY_DEPTH))
        begin
            win_len = HC_W'(HISTORY_DEPTH);
        end
        else
        begin
            win_len = HC_W'(win_ext);
        end
        ptr_ext = HC_W'(ptr_reg);
        if (ptr_ext >= win_len)
        begin
            rd_sum = ptr_ext - win_len;
        end
        else
        begin
            rd_sum = ptr_ext + (HC_W'(HISTORY_DEPTH) - win_len);
        end
        rd_addr = rd_sum[AW-1:0];
    end

    cpt_ram #(
        .WIDTH (PX_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ptr_reg),
        .wdata (mean_c),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Select mean, ball and past mean; entries not yet written hold the fill
    always_comb
    begin
        mean_c  = (count_reg != '0) ? quot_reg[PX_W-1:0] : prev_mean_reg;
        ball_c  = ball_valid_reg ? ball_reg : prev_mean_reg;
        if (primed_reg)
        begin
            fill_c = fill_reg;
        end
        else
        begin
            fill_c = (count_reg != '0) ? first_reg : prev_mean_reg;
        end
        old_c   = (hcount_reg >= win_len) ? ram_q : fill_c;
        ratio_c = (merge_ratio_reg > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                                          : merge_ratio_reg;
        ratio_inv    = RATIO_W'(RATIO_ONE) - ratio_c;
        diff_c       = $signed({1'b0, mean_c}) - $signed({1'b0, old_c});
        prod_mean_c  = ratio_c * mean_c;
        prod_ball_c  = ratio_inv * ball_c;
        speed_prod_c = diff_c * $signed({1'b0, frame_rate_reg});
    end

    // Advance history state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            hcount_reg    <= '0;
            primed_reg    <= 1'b0;
            fill_reg      <= '0;
            prev_mean_reg <= '0;
        end
        else if (cmd.commit)
        begin
            ptr_reg <= (ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            if (hcount_reg != HC_W'(HISTORY_DEPTH))
            begin
                hcount_reg <= hcount_reg + 1'b1;
            end
            primed_reg    <= 1'b1;
            fill_reg      <= fill_c;
            prev_mean_reg <= mean_c;
        end
    end

    // Hold products for the clamp stage
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            prod_mean_reg  <= prod_mean_c;
            prod_ball_reg  <= prod_ball_c;
            speed_prod_reg <= speed_prod_c;
            mean_reg       <= mean_c;
        end
    end

    // Round the blend and clamp target and speed
    always_comb
    begin
        blend_c = BLEND_W'(prod_mean_reg) + BLEND_W'(prod_ball_reg) + BLEND_W'(ROUND_HALF);
        tgt_raw = $signed(blend_c[RATIO_SHIFT +: TGT_W]);
        lo_c    = $signed(TGT_W'(left_bound_reg)) - $signed(TGT_W'(edge_margin_reg));
        hi_c    = $signed(TGT_W'(right_bound_reg)) + $signed(TGT_W'(edge_margin_reg));
        tgt_c   = tgt_raw;
        if (tgt_c < lo_c)
        begin
            tgt_c = lo_c;
        end
        if (tgt_c > hi_c)
        begin
            tgt_c = hi_c;
        end
        lim_c = $signed(SPROD_W'(speed_limit_reg));
        spd_c = speed_prod_reg;
        if (spd_c > lim_c)
        begin
            spd_c = lim_c;
        end
        if (spd_c < -lim_c)
        begin
            spd_c = -lim_c;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            target_reg   <= tgt_c;
            mean_out_reg <= mean_reg;
            speed_reg    <= spd_c[SPD_W-1:0];
        end
    end

    assign status.div_done = (step_reg == '0);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign pan_target = target_reg;
    assign mean_x     = mean_out_reg;
    assign pan_speed  = speed_reg;

endmodule

// ===== hw/rtl/camera_pan_target_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Camera pan target tracker
// Per frame mean player x, blended and clamped pan target, and clamped pan
// speed against the mean a window of frames earlier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | player_x has_player ball_x
//          |           |                       | has_ball frame_end
//  out     | output    | out_valid / out_ready | pan_target mean_x pan_speed
//  cfg     | input     | cfg_we                | cfg_index cfg_data
//
//  Words that do not end a frame are taken back to back.
//  After a frame-end word is taken the input stays closed through the
//  divider load, one quotient bit a cycle from the shift-subtract divider
//  over the SUM_W = 16 + clog2(MAX_PLAYERS+1) bit sum, the product step,
//  then the result register load.
//  The result register loads only once the previous result has been taken;
//  a stalled output adds its stall to that frame-end word.
//  No clearing pass after reset: unwritten history entries read as the fill.
// ----------------------------------------------------------------------------
module camera_pan_target_tracker_unit #(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_PLAYERS   = 32,
    parameter int POS_FRAC_BITS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cpt_pkg::PX_W-1:0]         player_x,
    input  logic                             has_player,
    input  logic [cpt_pkg::PX_W-1:0]         ball_x,
    input  logic                             has_ball,
    input  logic                             frame_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [cpt_pkg::TGT_W-1:0] pan_target,
    output logic [cpt_pkg::PX_W-1:0]         mean_x,
    output logic signed [cpt_pkg::SPD_W-1:0] pan_speed,
    input  logic                             cfg_we,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cpt_pkg::*;

    cpt_cmd_t    cmd;
    cpt_status_t status;

    cpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .status    (status)
    );

    cpt_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_PLAYERS   (MAX_PLAYERS),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .player_x   (player_x),
        .has_player (has_player),
        .ball_x     (ball_x),
        .has_ball   (has_ball),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .pan_target (pan_target),
        .mean_x     (mean_x),
        .pan_speed  (pan_speed)
    );

endmodule

// ===== hw/rtl/cpt_checker.sv =====
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the top-level ports for result hand-off and frame sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             frame_end,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [cpt_pkg::TGT_W-1:0] pan_target,
    input logic [cpt_pkg::PX_W-1:0]         mean_x,
    input logic signed [cpt_pkg::SPD_W-1:0] pan_speed
);
    import cpt_pkg::*;

    localparam int WORD_W = TGT_W + PX_W + SPD_W;

    logic [WORD_W-1:0] out_word;
    logic              out_stall;
    logic              end_taken;
    logic              tgt_in_range;

    // Gather the result word and the conditions watched below
    assign out_word     = {pan_target, mean_x, pan_speed};
    assign out_stall    = out_valid && !out_ready;
    assign end_taken    = in_valid && in_ready && frame_end;
    assign tgt_in_range = (pan_target >= -18'sd16383) && (pan_target <= 18'sd81918);

    // Hold a stalled result word
    `CPT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

    // Go busy after a frame-end word
    `CPT_ASSERT_NEXT(a_busy_after_end, end_taken, !in_ready, "input open after frame end")

    // Keep target within the widest possible court window
    `CPT_ASSERT_NOW(a_target_range, out_valid, tgt_in_range, "target outside court window")

    // Raise a result only from the busy phase
    `CPT_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready), "result while open")

endmodule

bind camera_pan_target_tracker_unit cpt_checker u_cpt_checker (.*);

// ===== tb/camera_pan_target_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera pan target tracker testbench
// Sends frames of player and ball words over the valid/ready input. For every
// accepted word it tracks the frame sums and the mean history itself and works
// out the pan result due on the frame-end word. Each result word is compared
// field by field with the oldest result due. The run covers several register
// settings, extremes among them, and several idle and stall patterns.
// ----------------------------------------------------------------------------
module camera_pan_target_tracker_unit_tb;
    import cpt_pkg::*;

    localparam int HIST_DEPTH      = 64;
    localparam int PLAYER_CAP      = 32;
    localparam int FRAC_BITS       = 4;
    localparam int REG_COUNT       = 7;
    localparam int SETTLE_CYCLES   = 40;
    localparam int REPORT_LIMIT    = 10;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 48;
    localparam int DIRECTED_ROWS   = 16;

    typedef struct packed {
        logic [PX_W-1:0] player;
        logic            player_ok;
        logic [PX_W-1:0] ball;
        logic            ball_ok;
        logic            last;
    } frame_word_t;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [PX_W-1:0]  mean;
        logic [SPD_W-1:0] speed;
    } pan_result_t;

    typedef struct {
        bit          pinned;
        pan_result_t fixed;
    } word_tag_t;

    // One directed word; a pinned row carries the result its frame must give
    typedef struct {
        logic [PX_W-1:0] player;
        logic            player_ok;
        logic [PX_W-1:0] ball;
        logic            ball_ok;
        logic            last;
        bit              pinned;
        int              target;
        int              mean;
        int              speed;
    } stim_row_t;

    stim_row_t directed [DIRECTED_ROWS] = '{
        // first frame: history filled with the first player, not the mean
        '{16'd4000,  1'b1, 16'd0,     1'b0, 1'b0, 1'b0, 0,     0,     0},
        '{16'd4060,  1'b1, 16'd0,     1'b0, 1'b1, 1'b1, 2015,  4030,  900},
        // top of range: target clamps to the right bound, speed to the limit
        '{16'hFFFF,  1'b1, 16'hFFFF,  1'b1, 1'b1, 1'b1, 30720, 65535, 16000},
        // bottom of range: speed clamps to minus the limit
        '{16'd0,     1'b1, 16'd0,     1'b1, 1'b1, 1'b1, 0,     0,     -16000},
        // empty frame: mean and ball both fall back to the previous mean
        '{16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 1'b1, 0,     0,     -16000},
        // several players, several balls: the first ball counts
        '{16'd100,   1'b1, 16'd500,   1'b1, 1'b0, 1'b0, 0,     0,     0},
        '{16'd300,   1'b1, 16'd9000,  1'b1, 1'b0, 1'b0, 0,     0,     0},
        '{16'd0,     1'b1, 16'd0,     1'b0, 1'b0, 1'b0, 0,     0,     0},
        '{16'hFFFF,  1'b1, 16'd7,     1'b1, 1'b1, 1'b0, 0,     0,     0},
        // no ball in frame
        '{16'd1000,  1'b1, 16'd0,     1'b0, 1'b0, 1'b0, 0,     0,     0},
        '{16'd2000,  1'b1, 16'hFFFF,  1'b0, 1'b1, 1'b0, 0,     0,     0},
        // alternating bit patterns
        '{16'hAAAA,  1'b1, 16'h5555,  1'b1, 1'b1, 1'b0, 0,     0,     0},
        '{16'h5555,  1'b1, 16'hAAAA,  1'b0, 1'b1, 1'b0, 0,     0,     0},
        // words with nothing valid, then a ball-only frame
        '{16'd12345, 1'b0, 16'd54321, 1'b0, 1'b0, 1'b0, 0,     0,     0},
        '{16'd0,     1'b0, 16'd0,     1'b1, 1'b0, 1'b0, 0,     0,     0},
        '{16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 1'b0, 0,     0,     0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [PX_W-1:0]         player_x;
    logic                    has_player;
    logic [PX_W-1:0]         ball_x;
    logic                    has_ball;
    logic                    frame_end;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [TGT_W-1:0] pan_target;
    logic [PX_W-1:0]         mean_x;
    logic signed [SPD_W-1:0] pan_speed;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Register copies
    logic [PX_W-1:0]      left_q;
    logic [PX_W-1:0]      right_q;
    logic [MARGIN_W-1:0]  margin_q;
    logic [RATIO_W-1:0]   ratio_q;
    logic [LIMIT_W-1:0]   limit_q;
    logic [RATE_W-1:0]    rate_q;
    logic [WIN_CFG_W-1:0] win_q;

    // Tracking state
    logic [PX_W-1:0] mean_hist [HIST_DEPTH];
    int unsigned     hist_ptr;
    bit              hist_primed;
    int unsigned     frame_sum;
    int unsigned     frame_players;
    logic [PX_W-1:0] frame_first;
    logic [PX_W-1:0] frame_ball;
    bit              frame_ball_seen;
    logic [PX_W-1:0] last_mean;

    pan_result_t pan_results_due [$];
    word_tag_t   sent_tags [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          scene_x;

    camera_pan_target_tracker_unit #(
        .HISTORY_DEPTH (HIST_DEPTH),
        .MAX_PLAYERS   (PLAYER_CAP),
        .POS_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .player_x   (player_x),
        .has_player (has_player),
        .ball_x     (ball_x),
        .has_ball   (has_ball),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pan_target (pan_target),
        .mean_x     (mean_x),
        .pan_speed  (pan_speed),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Mirror a register write, masked to the register's width
    function automatic void set_register(input cpt_reg_t idx,
                                         input logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_LEFT_BOUND:    left_q   = v[PX_W-1:0];
            REG_RIGHT_BOUND:   right_q  = v[PX_W-1:0];
            REG_EDGE_MARGIN:   margin_q = v[MARGIN_W-1:0];
            REG_MERGE_RATIO:   ratio_q  = v[RATIO_W-1:0];
            REG_SPEED_LIMIT:   limit_q  = v[LIMIT_W-1:0];
            REG_FRAME_RATE:    rate_q   = v[RATE_W-1:0];
            REG_WINDOW_LENGTH: win_q    = v[WIN_CFG_W-1:0];
            default: ;
        endcase
    endfunction

    // Fold one word into the frame; on the frame end, form the pan result
    function automatic bit track_word(input frame_word_t w, output pan_result_t r);
        int unsigned mean;
        int unsigned ball;
        int unsigned win;
        int unsigned slot;
        int unsigned ratio;
        longint      old;
        longint      speed;
        longint      lim;
        longint      target;
        longint      lo;
        longint      hi;
        r = '0;
        if (w.player_ok && frame_players < PLAYER_CAP)
        begin
            if (frame_players == 0)
                frame_first = w.player;
            frame_sum += w.player;
            frame_players++;
        end
        if (w.ball_ok && !frame_ball_seen)
        begin
            frame_ball      = w.ball;
            frame_ball_seen = 1'b1;
        end
        if (!w.last)
            return 1'b0;

        mean = (frame_players != 0) ? frame_sum / frame_players : last_mean;
        ball = frame_ball_seen ? frame_ball : last_mean;

        // prime the whole history on the very first frame
        if (!hist_primed)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                mean_hist[i] = (frame_players != 0) ? frame_first : last_mean;
            hist_primed = 1'b1;
        end

        win = win_q;
        if (win == 0)
            win = 1;
        if (win > HIST_DEPTH)
            win = HIST_DEPTH;
        slot = hist_ptr;
        old  = mean_hist[(slot + HIST_DEPTH - win) % HIST_DEPTH];
        mean_hist[slot] = mean[PX_W-1:0];
        hist_ptr = (slot + 1) % HIST_DEPTH;

        speed = (longint'(mean) - old) * longint'(rate_q);
        lim   = longint'(limit_q);
        if (speed > lim)
            speed = lim;
        if (speed < -lim)
            speed = -lim;

        ratio  = (ratio_q > RATIO_ONE) ? RATIO_ONE : ratio_q;
        target = longint'((ratio * mean + (RATIO_ONE - ratio) * ball + ROUND_HALF)
                          >> RATIO_SHIFT);
        lo = longint'(left_q) - longint'(margin_q);
        hi = longint'(right_q) + longint'(margin_q);
        if (target < lo)
            target = lo;
        if (target > hi)
            target = hi;

        last_mean       = mean[PX_W-1:0];
        frame_sum       = 0;
        frame_players   = 0;
        frame_first     = '0;
        frame_ball      = '0;
        frame_ball_seen = 1'b0;

        r.target = target[TGT_W-1:0];
        r.mean   = mean[PX_W-1:0];
        r.speed  = speed[SPD_W-1:0];
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input pan_result_t want,
                                          input pan_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected target %0d mean %0d speed %0d, got target %0d mean %0d speed %0d",
                     $realtime, what, $signed(want.target), want.mean, $signed(want.speed),
                     $signed(got.target), got.mean, $signed(got.speed));
    endfunction

    function automatic int clip_position(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // Mostly near the play, sometimes anywhere, now and then at the edges
    function automatic logic [PX_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 35)
            return PX_W'($urandom());
        return PX_W'(clip_position(scene_x + int'($urandom_range(0, 3000)) - 1500));
    endfunction

    // Drive the stall pattern of the result side
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Check result words, then track accepted input words
    always @(posedge clk)
    begin : score
        word_tag_t   tag;
        pan_result_t got;
        pan_result_t want;
        pan_result_t calc;
        frame_word_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.target = pan_target;
                got.mean   = mean_x;
                got.speed  = pan_speed;
                if (pan_results_due.size() == 0)
                    note_mismatch("result word with none due", '0, got);
                else
                begin
                    want = pan_results_due.pop_front();
                    if (got.target !== want.target || got.mean !== want.mean
                        || got.speed !== want.speed)
                        note_mismatch("result word differs", want, got);
                end
            end
            if (in_valid && in_ready)
            begin
                seen.player    = player_x;
                seen.player_ok = has_player;
                seen.ball      = ball_x;
                seen.ball_ok   = has_ball;
                seen.last      = frame_end;
                tag = sent_tags.pop_front();
                if (track_word(seen, calc))
                    pan_results_due.insert(pan_results_due.size(),
                                           tag.pinned ? tag.fixed : calc);
            end
        end
    end

    // Offer one word, with a random gap before it, and hold it until taken
    task automatic send_word(input frame_word_t w, input bit pinned,
                             input pan_result_t fixed);
        word_tag_t tag;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        tag.pinned = pinned;
        tag.fixed  = fixed;
        sent_tags.insert(sent_tags.size(), tag);
        in_valid   <= 1'b1;
        player_x   <= w.player;
        has_player <= w.player_ok;
        ball_x     <= w.ball;
        has_ball   <= w.ball_ok;
        frame_end  <= w.last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // One random frame: mostly a few players, sometimes an overfull crowd
    task automatic send_frame(output int counted);
        frame_word_t w;
        int          n;
        int          shape;
        shape = $urandom_range(0, 99);
        n = (shape < 8) ? $urandom_range(PLAYER_CAP + 1, PLAYER_CAP + 6)
                        : $urandom_range(1, 6);
        scene_x = clip_position(scene_x + int'($urandom_range(0, 800)) - 400);
        counted = 0;
        for (int k = 0; k < n; k++)
        begin
            w.player    = pick_position();
            w.player_ok = (shape >= 8 && shape < 14) ? 1'b0 : ($urandom_range(0, 99) < 85);
            w.ball      = pick_position();
            w.ball_ok   = ($urandom_range(0, 99) < 30);
            w.last      = (k == n - 1);
            counted++;
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic write_reg(input cpt_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        set_register(idx, v);
    endtask

    task automatic pick_settings(input int phase,
                                 output logic [CFG_DATA_W-1:0] knob [REG_COUNT]);
        case (phase)
            0:
            begin
                knob[REG_LEFT_BOUND]    = 2000;
                knob[REG_RIGHT_BOUND]   = 28000;
                knob[REG_EDGE_MARGIN]   = 500;
                knob[REG_MERGE_RATIO]   = 200;
                knob[REG_SPEED_LIMIT]   = 50000;
                knob[REG_FRAME_RATE]    = 60;
                knob[REG_WINDOW_LENGTH] = 5;
            end
            1:
            begin
                knob[REG_LEFT_BOUND]    = 0;
                knob[REG_RIGHT_BOUND]   = 65535;
                knob[REG_EDGE_MARGIN]   = 16383;
                knob[REG_MERGE_RATIO]   = 0;
                knob[REG_SPEED_LIMIT]   = 1048575;
                knob[REG_FRAME_RATE]    = 240;
                knob[REG_WINDOW_LENGTH] = 1;
            end
            2:
            begin
                knob[REG_LEFT_BOUND]    = 30000;
                knob[REG_RIGHT_BOUND]   = 30000;
                knob[REG_EDGE_MARGIN]   = 0;
                knob[REG_MERGE_RATIO]   = 256;
                knob[REG_SPEED_LIMIT]   = 1;
                knob[REG_FRAME_RATE]    = 1;
                knob[REG_WINDOW_LENGTH] = 64;
            end
            3:
            begin
                // crossed bounds, ratio past one, zero rate and zero window
                knob[REG_LEFT_BOUND]    = 40000;
                knob[REG_RIGHT_BOUND]   = 20000;
                knob[REG_EDGE_MARGIN]   = 5000;
                knob[REG_MERGE_RATIO]   = 511;
                knob[REG_SPEED_LIMIT]   = 100;
                knob[REG_FRAME_RATE]    = 0;
                knob[REG_WINDOW_LENGTH] = 0;
            end
            4:
            begin
                // zero limit, window past the history depth
                knob[REG_LEFT_BOUND]    = 65535;
                knob[REG_RIGHT_BOUND]   = 0;
                knob[REG_EDGE_MARGIN]   = 0;
                knob[REG_MERGE_RATIO]   = 300;
                knob[REG_SPEED_LIMIT]   = 0;
                knob[REG_FRAME_RATE]    = 255;
                knob[REG_WINDOW_LENGTH] = 127;
            end
            5:
            begin
                knob[REG_LEFT_BOUND]    = $urandom_range(0, 20000);
                knob[REG_RIGHT_BOUND]   = $urandom_range(20000, 65535);
                knob[REG_EDGE_MARGIN]   = $urandom_range(0, 16383);
                knob[REG_MERGE_RATIO]   = $urandom_range(0, RATIO_ONE);
                knob[REG_SPEED_LIMIT]   = $urandom_range(1, 1048575);
                knob[REG_FRAME_RATE]    = $urandom_range(1, 240);
                knob[REG_WINDOW_LENGTH] = $urandom_range(1, HIST_DEPTH);
            end
            default:
            begin
                // raw data words, upper bits past each register included
                foreach (knob[i])
                    knob[i] = CFG_DATA_W'($urandom());
            end
        endcase
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] knob [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(cpt_reg_t'(i), knob[i]);
        cfg_we <= 1'b0;
    endtask

    // Wait out every result due, then the block's own latency
    task automatic drain();
        // let the last accepted word reach the due queue first
        @(posedge clk);
        while (pan_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] knob [REG_COUNT];
        pan_result_t           fixed;
        frame_word_t           w;
        int                    sent;
        int                    counted;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        player_x       = '0;
        has_player     = 1'b0;
        ball_x         = '0;
        has_ball       = 1'b0;
        frame_end      = 1'b0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_LEFT_BOUND;
        cfg_data       = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        scene_x        = 15000;

        // reset state of the copies
        left_q          = LEFT_RESET;
        right_q         = COURT_WIDTH_PX << FRAC_BITS;
        margin_q        = MARGIN_RESET;
        ratio_q         = RATIO_RESET;
        limit_q         = LIMIT_RESET;
        rate_q          = RATE_RESET;
        win_q           = WIN_RESET;
        hist_ptr        = 0;
        hist_primed     = 1'b0;
        frame_sum       = 0;
        frame_players   = 0;
        frame_first     = '0;
        frame_ball      = '0;
        frame_ball_seen = 1'b0;
        last_mean       = '0;
        foreach (mean_hist[i])
            mean_hist[i] = '0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table on the reset settings
        foreach (directed[i])
        begin
            w.player     = directed[i].player;
            w.player_ok  = directed[i].player_ok;
            w.ball       = directed[i].ball;
            w.ball_ok    = directed[i].ball_ok;
            w.last       = directed[i].last;
            fixed.target = directed[i].target[TGT_W-1:0];
            fixed.mean   = directed[i].mean[PX_W-1:0];
            fixed.speed  = directed[i].speed[SPD_W-1:0];
            send_word(w, directed[i].pinned, fixed);
        end
        in_valid <= 1'b0;
        drain();

        // random frames, one register setting and idle pattern per phase
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            pick_settings(phase, knob);
            load_settings(knob);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                send_frame(counted);
                sent += counted;
            end
            in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && pan_results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
